/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rccc_pkg.sv */
// Types and constants for the channel calibrate and classify unit.
package rccc_pkg;

	localparam int NUM_CHANNELS_DEF = 32;
	localparam int SLOT_COUNT_DEF   = 6;

	localparam int ONE_Q14 = 16384;
	localparam int QUO_W   = 15;

	localparam logic MODE_WRITE   = 1'b0;
	localparam logic MODE_CONVERT = 1'b1;

	localparam logic [1:0] POS_NONE = 2'd0;
	localparam logic [1:0] POS_OFF  = 2'd1;
	localparam logic [1:0] POS_MID  = 2'd2;
	localparam logic [1:0] POS_ON   = 2'd3;

	typedef struct packed {
		logic               mode;
		logic [4:0]         channel;
		logic [11:0]        pulse_us;
		logic [11:0]        cal_min;
		logic [11:0]        cal_trim;
		logic [11:0]        cal_max;
		logic [6:0]         cal_deadzone;
		logic               cal_reverse;
		logic signed [15:0] on_threshold;
		logic signed [15:0] mid_threshold;
		logic               two_position;
	} req_t;

	typedef struct packed {
		logic signed [15:0] calibrated;
		logic [1:0]         switch_position;
		logic [2:0]         flight_slot;
	} rsp_t;

	typedef struct packed {
		logic [11:0] lo;
		logic [11:0] mid;
		logic [11:0] hi;
		logic [6:0]  band;
		logic        flip;
	} cal_entry_t;

endpackage

/* hdl/rc_channel_calibrate_classify_unit.sv */
// Pipelined RC pulse calibration, switch classification and mode slot mapping.
// Takes one request per cycle and returns one response per request, in order,
// through registered steps: table read, clamp, side select, a 15-stage
// one-bit-per-stage divider, sign apply, classify; the response register and a
// common stall keep full throughput whenever the response side takes every cycle.
// A write request (mode 0) stores the channel's min, trim, max, deadzone and
// reverse and answers with all zeros; a convert request reads that entry, so a
// channel must be written before it is converted.
module rc_channel_calibrate_classify_unit #(
	parameter int NUM_CHANNELS = rccc_pkg::NUM_CHANNELS_DEF,
	parameter int SLOT_COUNT   = rccc_pkg::SLOT_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rccc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rccc_pkg::rsp_t rsp
);

	localparam int CH_W   = $clog2(NUM_CHANNELS);
	localparam int QW     = rccc_pkg::QUO_W;
	localparam int SLOT_W = $clog2(SLOT_COUNT + 1);

	typedef struct packed {
		logic               nul;
		logic [11:0]        pulse;
		logic signed [15:0] on_th;
		logic signed [15:0] mid_th;
		logic               two_pos;
	} s1_t;

	typedef struct packed {
		logic               nul;
		logic [11:0]        v;
		logic [12:0]        mid_p;
		logic signed [13:0] mid_m;
		logic [11:0]        lo;
		logic [11:0]        hi;
		logic               flip;
		logic signed [15:0] on_th;
		logic signed [15:0] mid_th;
		logic               two_pos;
	} s2_t;

	typedef struct packed {
		logic               nul;
		logic               zero;
		logic               sat;
		logic               neg;
		logic [12:0]        rem;
		logic [12:0]        dv;
		logic [QW-1:0]      dbits;
		logic [QW-1:0]      quo;
		logic signed [15:0] on_th;
		logic signed [15:0] mid_th;
		logic               two_pos;
	} div_t;

	typedef struct packed {
		logic               nul;
		logic signed [15:0] c;
		logic signed [15:0] on_th;
		logic signed [15:0] mid_th;
		logic               two_pos;
	} sc_t;

	rccc_pkg::cal_entry_t cal_mem [NUM_CHANNELS];

	logic adv;
	logic acc;
	logic in_range;

	logic                 v_s1, v_s2, v_s3, v_sc;
	s1_t                  d_s1;
	rccc_pkg::cal_entry_t e_s1;
	s2_t                  d_s2;
	logic                 v_div [QW+1];
	div_t                 d_div [QW+1];
	sc_t                  d_sc;
	logic                 rsp_valid_q;
	rccc_pkg::rsp_t       rsp_q;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = adv;
	assign acc       = req_valid && adv;
	assign in_range  = 32'(req.channel) < NUM_CHANNELS;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Table write and registered table read at acceptance.
	always_ff @(posedge clk) begin
		if (acc) begin
			if (req.mode == rccc_pkg::MODE_WRITE && in_range) begin
				cal_mem[CH_W'(req.channel)] <= '{lo: req.cal_min, mid: req.cal_trim,
					hi: req.cal_max, band: req.cal_deadzone, flip: req.cal_reverse};
			end
			e_s1 <= cal_mem[CH_W'(req.channel)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1.nul     <= req.mode == rccc_pkg::MODE_WRITE || !in_range || req.pulse_us == '0;
			d_s1.pulse   <= req.pulse_us;
			d_s1.on_th   <= req.on_threshold;
			d_s1.mid_th  <= req.mid_threshold;
			d_s1.two_pos <= req.two_position;
		end
	end

	// Stage 2: clamp and band edges.
	logic [11:0] clamp_v;
	always_comb begin
		if (d_s1.pulse < e_s1.lo) begin
			clamp_v = e_s1.lo;
		end else if (d_s1.pulse > e_s1.hi) begin
			clamp_v = e_s1.hi;
		end else begin
			clamp_v = d_s1.pulse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2.nul     <= d_s1.nul;
			d_s2.v       <= clamp_v;
			d_s2.mid_p   <= {1'b0, e_s1.mid} + {6'd0, e_s1.band};
			d_s2.mid_m   <= $signed({2'b00, e_s1.mid}) - $signed({7'd0, e_s1.band});
			d_s2.lo      <= e_s1.lo;
			d_s2.hi      <= e_s1.hi;
			d_s2.flip    <= e_s1.flip;
			d_s2.on_th   <= d_s1.on_th;
			d_s2.mid_th  <= d_s1.mid_th;
			d_s2.two_pos <= d_s1.two_pos;
		end
	end

	// Stage 3: pick side, numerator and divisor, load the divider.
	logic               above, below;
	logic [11:0]        num;
	logic signed [13:0] den;
	logic [13:0]        num_b;
	always_comb begin
		above = {1'b0, d_s2.v} > d_s2.mid_p;
		below = $signed({2'b00, d_s2.v}) < d_s2.mid_m;
		num_b = 14'(d_s2.mid_m - $signed({2'b00, d_s2.v}));
		if (above) begin
			num = 12'({1'b0, d_s2.v} - d_s2.mid_p);
			den = $signed({2'b00, d_s2.hi}) - $signed({1'b0, d_s2.mid_p});
		end else begin
			num = num_b[11:0];
			den = d_s2.mid_m - $signed({2'b00, d_s2.lo});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_div[0] <= 1'b0;
		end else if (adv) begin
			v_div[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_div[0].nul     <= d_s2.nul;
			d_div[0].zero    <= !above && !below;
			d_div[0].sat     <= den <= 14'sd0 || $signed({2'b00, num}) >= den;
			d_div[0].neg     <= below ^ d_s2.flip;
			d_div[0].rem     <= {1'b0, num};
			d_div[0].dv      <= {den[11:0], 1'b0};
			d_div[0].dbits   <= QW'(den[11:0]);
			d_div[0].quo     <= '0;
			d_div[0].on_th   <= d_s2.on_th;
			d_div[0].mid_th  <= d_s2.mid_th;
			d_div[0].two_pos <= d_s2.two_pos;
		end
	end

	// Restoring divider, one quotient bit per stage.
	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [13:0] r2;
		logic        qb;
		div_t        nxt;
		assign r2 = {d_div[i].rem, d_div[i].dbits[QW-1]};
		assign qb = r2 >= {1'b0, d_div[i].dv};

		always_comb begin
			nxt       = d_div[i];
			nxt.rem   = qb ? 13'(r2 - {1'b0, d_div[i].dv}) : r2[12:0];
			nxt.dbits = {d_div[i].dbits[QW-2:0], 1'b0};
			nxt.quo   = {d_div[i].quo[QW-2:0], qb};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_div[i+1] <= 1'b0;
			end else if (adv) begin
				v_div[i+1] <= v_div[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d_div[i+1] <= nxt;
			end
		end
	end

	// Saturate and apply sign.
	logic [15:0] mag;
	always_comb begin
		if (d_div[QW].zero) begin
			mag = '0;
		end else if (d_div[QW].sat) begin
			mag = 16'(rccc_pkg::ONE_Q14);
		end else begin
			mag = {1'b0, d_div[QW].quo};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else if (adv) begin
			v_sc <= v_div[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_sc.nul     <= d_div[QW].nul;
			d_sc.c       <= d_div[QW].neg ? -$signed(mag) : $signed(mag);
			d_sc.on_th   <= d_div[QW].on_th;
			d_sc.mid_th  <= d_div[QW].mid_th;
			d_sc.two_pos <= d_div[QW].two_pos;
		end
	end

	// Classify: switch thresholds and mode slot boundaries.
	logic [16:0]           s_val;
	logic                  pass_on, pass_mid;
	logic [SLOT_COUNT-2:0] slot_hit;
	logic [SLOT_W-1:0]     slot_cnt;
	logic [1:0]            pos;

	// Compare against twice the threshold magnitude; a negative threshold flips the test.
	function automatic logic th_pass(logic [16:0] s, logic signed [15:0] th);
		logic [16:0] mag_th;
		mag_th = th[15] ? 17'(-$signed({th[15], th})) : {1'b0, th};
		return th[15] ? ({1'b0, s} < {mag_th, 1'b0}) : ({1'b0, s} > {mag_th, 1'b0});
	endfunction

	assign s_val    = 17'($signed({d_sc.c[15], d_sc.c}) + 17'sd16384);
	assign pass_on  = th_pass(s_val, d_sc.on_th);
	assign pass_mid = th_pass(s_val, d_sc.mid_th);

	for (genvar k = 1; k < SLOT_COUNT; k++) begin : g_slot
		localparam longint A = longint'(k) * 688128 * SLOT_COUNT - 1015808
			- longint'(SLOT_COUNT) * SLOT_COUNT * 344064;
		localparam longint B = longint'(20) * SLOT_COUNT * SLOT_COUNT;
		localparam longint T = (A >= 0) ? (A + B - 1) / B : -((-A) / B);
		localparam logic signed [17:0] T18 = 18'(T);
		assign slot_hit[k-1] = $signed({{2{d_sc.c[15]}}, d_sc.c}) >= T18;
	end

	always_comb begin
		slot_cnt = SLOT_W'(1);
		for (int j = 0; j < SLOT_COUNT - 1; j++) begin
			slot_cnt = slot_cnt + SLOT_W'(slot_hit[j]);
		end
		if (pass_on) begin
			pos = rccc_pkg::POS_ON;
		end else if (!d_sc.two_pos && pass_mid) begin
			pos = rccc_pkg::POS_MID;
		end else begin
			pos = rccc_pkg::POS_OFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (d_sc.nul) begin
				rsp_q <= '{calibrated: '0, switch_position: rccc_pkg::POS_NONE, flight_slot: '0};
			end else begin
				rsp_q.calibrated      <= d_sc.c;
				rsp_q.switch_position <= pos;
				rsp_q.flight_slot     <= 3'(slot_cnt);
			end
		end
	end

endmodule

/* hdl/rccc_checker.sv */
// Port-level checker for the calibrate and classify unit, with its bind.
`include "assert_macros.svh"

module rccc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input rccc_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input rccc_pkg::rsp_t rsp
);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp), "response dropped or changed while stalled")
	`ASSERT_CLK(a_ready_free, clk, arst_n, rsp_ready |-> req_ready,
		"request side blocked while response side takes")
	`ASSERT_CLK(a_none_zero, clk, arst_n,
		rsp_valid && rsp.switch_position == rccc_pkg::POS_NONE |->
		rsp.flight_slot == 3'd0 && rsp.calibrated == 16'sd0, "empty response carries data")
	`ASSERT_CLK(a_slot_set, clk, arst_n,
		rsp_valid && rsp.switch_position != rccc_pkg::POS_NONE |-> rsp.flight_slot != 3'd0,
		"classified response without slot")
	`ASSERT_CLK(a_range, clk, arst_n,
		rsp_valid |-> rsp.calibrated >= -16'sd16384 && rsp.calibrated <= 16'sd16384,
		"calibrated value out of range")

endmodule

bind rc_channel_calibrate_classify_unit rccc_checker u_rccc_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready), .req(req),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
